[sv/bbc_pkg.sv]
// bbc_pkg: shared types and constants of the bracket balance checker.
// No dependencies.
package bbc_pkg;

	localparam int unsigned MAX_NESTING_DEF = 255;
	localparam int unsigned CH_W = 8;
	localparam int unsigned ERR_W = 4;

	localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
	localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
	localparam logic [CH_W-1:0] CH_LSQ   = 8'h5B;
	localparam logic [CH_W-1:0] CH_RSQ   = 8'h5D;
	localparam logic [CH_W-1:0] CH_LCUR  = 8'h7B;
	localparam logic [CH_W-1:0] CH_RCUR  = 8'h7D;
	localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CH_W-1:0] CH_BSL   = 8'h5C;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE       = 4'd0,
		ERR_STRAY_GT   = 4'd1,
		ERR_STRAY_RSQ  = 4'd2,
		ERR_STRAY_RCUR = 4'd3,
		ERR_ARRAY_EOL  = 4'd4,
		ERR_CUSTOM     = 4'd5,
		ERR_STRING     = 4'd6,
		ERR_STRUCT     = 4'd7,
		ERR_OVERFLOW   = 4'd8
	} bbc_err_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            end_of_text;
	} bbc_item_t;

	typedef struct packed {
		logic      valid;
		bbc_item_t item;
	} bbc_stage_t;

endpackage

[sv/bbc_if.sv]
// bbc_if: valid/ready channel interfaces for text words and result words.
// Depends on bbc_pkg.
interface bbc_in_if import bbc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            end_of_text;

	modport source (output valid, output ch, output end_of_text, input ready);
	modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface bbc_out_if import bbc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ERR_W-1:0] error_code;
	logic             finished;
	logic             accepted;

	modport source (output valid, output error_code, output finished, output accepted,
		input ready);
	modport sink (input valid, input error_code, input finished, input accepted,
		output ready);
endinterface

[sv/bracket_balance_checker_core.sv]
// bracket_balance_checker_core: streaming bracket balance checker, top level.
// Depends on bbc_pkg, bbc_if, bbc_in_stage and bbc_scan.
//
// text_in carries one text byte per word (ch) or an end-of-document word
// (end_of_text set, ch ignored). result_out returns exactly one word per
// input word: the sticky error so far for a byte, or the final verdict with
// finished set for an end word; accepted is set on a clean document.
// A word accepted on text_in sits in the input register and is then scanned
// into the result register, which drives valid on result_out; a stall on
// result_out holds it in the input register. Throughput is one word per
// cycle while result_out is not stalled, set by the state update in bbc_scan.
// Reset clears the bracket state and both valid flags; no words are held.
// When result_out is stalled, the result register holds its word, the input
// register takes one more word if it is empty, and then text_in.ready drops
// until the receiver takes the waiting result.
module bracket_balance_checker_core import bbc_pkg::*; #(
	parameter int unsigned MAX_NESTING = MAX_NESTING_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bbc_in_if.sink    text_in,
	bbc_out_if.source result_out
);

	bbc_stage_t stage_s1;
	logic       adv;

	bbc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.adv      (adv),
		.stage_s1 (stage_s1)
	);

	bbc_scan #(
		.MAX_NESTING (MAX_NESTING)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.stage_s1   (stage_s1),
		.adv        (adv),
		.result_out (result_out)
	);

endmodule

[sv/bbc_in_stage.sv]
// bbc_in_stage: input register of the checker.
// Depends on bbc_pkg and bbc_in_if.
module bbc_in_stage import bbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bbc_in_if.sink     text_in,
	input  logic       adv,
	output bbc_stage_t stage_s1
);

	logic       valid_s1;
	bbc_item_t  item_s1;
	logic       load;

	assign load           = !valid_s1 || adv;
	assign text_in.ready  = load;
	assign stage_s1.valid = valid_s1;
	assign stage_s1.item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && text_in.valid) begin
			item_s1.ch          <= text_in.ch;
			item_s1.end_of_text <= text_in.end_of_text;
		end
	end

endmodule

[sv/bbc_scan.sv]
// bbc_scan: bracket state, per-word update and result register.
// Depends on bbc_pkg and bbc_out_if.
module bbc_scan import bbc_pkg::*; #(
	parameter int unsigned MAX_NESTING = MAX_NESTING_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  bbc_stage_t stage_s1,
	output logic       adv,
	bbc_out_if.source  result_out
);

	localparam int unsigned DW = $clog2(MAX_NESTING + 1);
	localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NESTING);

	typedef struct packed {
		logic          in_custom;
		logic          in_array;
		logic          in_quote;
		logic          escape_pending;
		logic [DW-1:0] depth;
		bbc_err_t      sticky;
	} scan_state_t;

	localparam scan_state_t STATE_CLR = '{
		in_custom: 1'b0, in_array: 1'b0, in_quote: 1'b0, escape_pending: 1'b0,
		depth: '0, sticky: ERR_NONE};

	scan_state_t state_q;
	scan_state_t state_nxt;
	bbc_err_t    code;
	logic        consume;
	logic        out_valid_q;
	bbc_err_t    err_q;
	logic        fin_q;
	logic        acc_q;
	logic [CH_W-1:0] c;

	assign adv     = !out_valid_q || result_out.ready;
	assign consume = stage_s1.valid && adv;
	assign c       = stage_s1.item.ch;

	always_comb begin
		state_nxt = state_q;
		code      = state_q.sticky;
		if (stage_s1.item.end_of_text) begin
			if (state_q.sticky == ERR_NONE) begin
				if (state_q.in_array)
					code = ERR_ARRAY_EOL;
				else if (state_q.in_custom)
					code = ERR_CUSTOM;
				else if (state_q.in_quote)
					code = ERR_STRING;
				else if (state_q.depth != '0)
					code = ERR_STRUCT;
			end
			state_nxt = STATE_CLR;
		end else begin
			if (state_q.sticky == ERR_NONE) begin
				if (c == CH_NL && !state_q.in_custom) begin
					if (state_q.in_array)
						state_nxt.sticky = ERR_ARRAY_EOL;
					state_nxt.in_array       = 1'b0;
					state_nxt.escape_pending = 1'b0;
				end else if (state_q.in_custom) begin
					if (c == CH_GT)
						state_nxt.in_custom = 1'b0;
				end else if (state_q.in_array) begin
					if (c == CH_RSQ)
						state_nxt.in_array = 1'b0;
				end else if (state_q.in_quote) begin
					if (state_q.escape_pending)
						state_nxt.escape_pending = 1'b0;
					else if (c == CH_QUOTE)
						state_nxt.in_quote = 1'b0;
					else if (c == CH_BSL)
						state_nxt.escape_pending = 1'b1;
				end else if (c == CH_RCUR && state_q.depth != '0) begin
					state_nxt.depth = state_q.depth - DW'(1);
				end else begin
					unique case (c)
						CH_LT:    state_nxt.in_custom = 1'b1;
						CH_LSQ:   state_nxt.in_array  = 1'b1;
						CH_QUOTE: state_nxt.in_quote  = 1'b1;
						CH_LCUR: begin
							if (state_q.depth >= DEPTH_MAX)
								state_nxt.sticky = ERR_OVERFLOW;
							else
								state_nxt.depth = state_q.depth + DW'(1);
						end
						CH_GT:    state_nxt.sticky = ERR_STRAY_GT;
						CH_RSQ:   state_nxt.sticky = ERR_STRAY_RSQ;
						CH_RCUR:  state_nxt.sticky = ERR_STRAY_RCUR;
						default:  ;
					endcase
				end
			end
			code = state_nxt.sticky;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_CLR;
			out_valid_q <= 1'b0;
		end else if (consume) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			err_q <= code;
			fin_q <= stage_s1.item.end_of_text;
			acc_q <= stage_s1.item.end_of_text && (code == ERR_NONE);
		end
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.error_code = err_q;
	assign result_out.finished   = fin_q;
	assign result_out.accepted   = acc_q;

endmodule

[sv/bbc_checker.sv]
// bbc_checker: port-level assertions for bracket_balance_checker_core.
// Depends on bbc_pkg; bound to the top level at the end of this file.
module bbc_checker import bbc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [ERR_W-1:0] error_code,
	input logic             finished,
	input logic             accepted
);

	a_reset_clears: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (finished && error_code == ERR_NONE))
		else $error("accepted without clean final verdict");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code <= ERR_OVERFLOW))
		else $error("error code out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(error_code) && $stable(finished) && $stable(accepted)))
		else $error("stalled result word changed");

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.error_code (result_out.error_code),
	.finished   (result_out.finished),
	.accepted   (result_out.accepted)
);

[sim/testbench.sv]
// testbench: self-checking bench for bracket_balance_checker_core with random handshake stalls.
// Directed table first, then random documents checked against an in-bench bracket scanner.
// Depends on bbc_pkg, bbc_if and bracket_balance_checker_core.
module testbench;
	import bbc_pkg::*;

	localparam int unsigned NEST_LIMIT = MAX_NESTING_DEF;
	localparam int unsigned RAND_ITEMS = 1070;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int N_ROWS = 25;

	typedef struct packed {
		logic in_custom;
		logic in_array;
		logic in_quote;
		logic escape;
		logic [8:0] depth;
		bbc_err_t err;
	} doc_state_t;

	typedef struct packed {
		bbc_err_t code;
		logic finished;
		logic accepted;
	} verdict_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic eot;
		logic [8:0] reps;
		logic typed;
		bbc_err_t code;
		logic fin;
		logic acc;
	} dir_row_t;

	logic clk;
	logic arst_n;
	bbc_in_if text_in();
	bbc_out_if result_out();

	doc_state_t doc;
	verdict_t verdict_q[$];
	int unsigned mismatches;
	int unsigned idle_cycles;
	bit send_burst;
	bit recv_burst;

	// rows with typed = 0 take their expectation from the scanner
	dir_row_t dir_rows [N_ROWS] = '{
		'{8'hFF,   1'b1, 9'd1,   1'b1, ERR_NONE,       1'b1, 1'b1},
		'{CH_GT,   1'b0, 9'd1,   1'b1, ERR_STRAY_GT,   1'b0, 1'b0},
		'{8'hFF,   1'b0, 9'd1,   1'b1, ERR_STRAY_GT,   1'b0, 1'b0},
		'{8'h00,   1'b1, 9'd1,   1'b1, ERR_STRAY_GT,   1'b1, 1'b0},
		'{CH_RSQ,  1'b0, 9'd1,   1'b1, ERR_STRAY_RSQ,  1'b0, 1'b0},
		'{8'h00,   1'b1, 9'd1,   1'b1, ERR_STRAY_RSQ,  1'b1, 1'b0},
		'{CH_RCUR, 1'b0, 9'd1,   1'b1, ERR_STRAY_RCUR, 1'b0, 1'b0},
		'{8'h00,   1'b1, 9'd1,   1'b1, ERR_STRAY_RCUR, 1'b1, 1'b0},
		'{CH_LSQ,  1'b0, 9'd1,   1'b0, ERR_NONE,       1'b0, 1'b0},
		'{CH_NL,   1'b0, 9'd1,   1'b1, ERR_ARRAY_EOL,  1'b0, 1'b0},
		'{8'h00,   1'b1, 9'd1,   1'b1, ERR_ARRAY_EOL,  1'b1, 1'b0},
		'{CH_LT,   1'b0, 9'd1,   1'b0, ERR_NONE,       1'b0, 1'b0},
		'{CH_NL,   1'b0, 9'd1,   1'b0, ERR_NONE,       1'b0, 1'b0},
		'{8'h00,   1'b1, 9'd1,   1'b1, ERR_CUSTOM,     1'b1, 1'b0},
		'{CH_QUOTE, 1'b0, 9'd1,  1'b0, ERR_NONE,       1'b0, 1'b0},
		'{CH_BSL,  1'b0, 9'd1,   1'b0, ERR_NONE,       1'b0, 1'b0},
		'{CH_QUOTE, 1'b0, 9'd1,  1'b0, ERR_NONE,       1'b0, 1'b0},
		'{8'h00,   1'b1, 9'd1,   1'b1, ERR_STRING,     1'b1, 1'b0},
		'{CH_LCUR, 1'b0, 9'd255, 1'b0, ERR_NONE,       1'b0, 1'b0},
		'{CH_LCUR, 1'b0, 9'd1,   1'b1, ERR_OVERFLOW,   1'b0, 1'b0},
		'{8'h00,   1'b1, 9'd1,   1'b1, ERR_OVERFLOW,   1'b1, 1'b0},
		'{CH_LCUR, 1'b0, 9'd1,   1'b0, ERR_NONE,       1'b0, 1'b0},
		'{8'h00,   1'b1, 9'd1,   1'b1, ERR_STRUCT,     1'b1, 1'b0},
		'{CH_LSQ,  1'b0, 9'd1,   1'b0, ERR_NONE,       1'b0, 1'b0},
		'{8'h00,   1'b1, 9'd1,   1'b1, ERR_ARRAY_EOL,  1'b1, 1'b0}
	};

	bracket_balance_checker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in),
		.result_out(result_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_doc();
		doc.in_custom = 1'b0;
		doc.in_array = 1'b0;
		doc.in_quote = 1'b0;
		doc.escape = 1'b0;
		doc.depth = '0;
		doc.err = ERR_NONE;
	endfunction

	// one word through the bracket scanner, returns the result word it causes
	function automatic verdict_t advance_doc(input logic [CH_W-1:0] c, input logic e);
		verdict_t r;
		bbc_err_t code;
		if (!e) begin
			if (doc.err == ERR_NONE) begin
				if (c == CH_NL && !doc.in_custom) begin
					if (doc.in_array)
						doc.err = ERR_ARRAY_EOL;
					doc.in_array = 1'b0;
					doc.escape = 1'b0;
				end else if (doc.in_custom) begin
					if (c == CH_GT)
						doc.in_custom = 1'b0;
				end else if (doc.in_array) begin
					if (c == CH_RSQ)
						doc.in_array = 1'b0;
				end else if (doc.in_quote) begin
					if (doc.escape)
						doc.escape = 1'b0;
					else if (c == CH_QUOTE)
						doc.in_quote = 1'b0;
					else if (c == CH_BSL)
						doc.escape = 1'b1;
				end else if (c == CH_RCUR && doc.depth != 0) begin
					doc.depth = doc.depth - 9'd1;
				end else begin
					case (c)
						CH_LT: doc.in_custom = 1'b1;
						CH_LSQ: doc.in_array = 1'b1;
						CH_QUOTE: doc.in_quote = 1'b1;
						CH_LCUR: begin
							if (doc.depth >= NEST_LIMIT)
								doc.err = ERR_OVERFLOW;
							else
								doc.depth = doc.depth + 9'd1;
						end
						CH_GT: doc.err = ERR_STRAY_GT;
						CH_RSQ: doc.err = ERR_STRAY_RSQ;
						CH_RCUR: doc.err = ERR_STRAY_RCUR;
						default: ;
					endcase
				end
			end
			r = '{doc.err, 1'b0, 1'b0};
		end else begin
			code = doc.err;
			if (code == ERR_NONE) begin
				if (doc.in_array)
					code = ERR_ARRAY_EOL;
				else if (doc.in_custom)
					code = ERR_CUSTOM;
				else if (doc.in_quote)
					code = ERR_STRING;
				else if (doc.depth != 0)
					code = ERR_STRUCT;
			end
			clear_doc();
			r = '{code, 1'b1, code == ERR_NONE};
		end
		return r;
	endfunction

	// mostly plausible text for the current context, some noise and stray closers
	function automatic logic [CH_W-1:0] body_byte(input bit deep);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 8'($urandom);
		if (doc.in_custom)
			return r < 25 ? CH_GT : (r < 35 ? CH_NL : 8'($urandom));
		if (doc.in_array)
			return r < 25 ? CH_RSQ : (r < 28 ? CH_NL : 8'($urandom_range(32, 126)));
		if (doc.in_quote)
			return r < 22 ? CH_QUOTE : (r < 38 ? CH_BSL :
				(r < 41 ? CH_NL : 8'($urandom_range(32, 126))));
		if (deep && r < 90)
			return CH_LCUR;
		if (r < 8)
			return r == 6 ? CH_GT : CH_RSQ;
		if (r < 18)
			return CH_LT;
		if (r < 30)
			return CH_LSQ;
		if (r < 42)
			return CH_QUOTE;
		if (r < 58)
			return CH_LCUR;
		if (r < 72)
			return (doc.depth != 0 || r < 60) ? CH_RCUR : CH_NL;
		if (r < 80)
			return CH_NL;
		return 8'($urandom_range(48, 122));
	endfunction

	task automatic send_word(input logic [CH_W-1:0] c, input logic e, input logic typed,
		input verdict_t fixed);
		int unsigned gap;
		verdict_t pred;
		gap = send_burst ? 0 : $urandom_range(0, 18);
		if ($urandom_range(0, 59) == 0)
			send_burst = !send_burst;
		if (gap > 0) begin
			text_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_in.valid <= 1'b1;
		text_in.ch <= c;
		text_in.end_of_text <= e;
		@(posedge clk);
		while (!text_in.ready)
			@(posedge clk);
		pred = advance_doc(c, e);
		verdict_q.push_back(typed ? fixed : pred);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		text_in.valid <= 1'b0;
		@(negedge clk);
		while (verdict_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned counted;
		int unsigned body;
		bit deep;
		bit sloppy;
		logic [CH_W-1:0] c;
		arst_n = 1'b0;
		text_in.valid = 1'b0;
		text_in.ch = '0;
		text_in.end_of_text = 1'b0;
		send_burst = 1'b0;
		clear_doc();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			repeat (dir_rows[i].reps)
				send_word(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed,
					'{dir_rows[i].code, dir_rows[i].fin, dir_rows[i].acc});
		hold_until_drained();

		counted = 0;
		while (counted < RAND_ITEMS) begin
			deep = ($urandom_range(0, 11) == 0);
			sloppy = ($urandom_range(0, 4) == 0);
			body = deep ? $urandom_range(250, 300) : $urandom_range(0, 40);
			if (body > RAND_ITEMS - counted)
				body = RAND_ITEMS - counted;
			repeat (body) begin
				c = body_byte(deep);
				counted++;
				send_word(c, 1'b0, 1'b0, '0);
			end
			// close whatever is still open so most documents pass
			while (!sloppy && doc.err == ERR_NONE && (doc.in_custom || doc.in_array ||
				doc.in_quote || doc.depth != 0)) begin
				if (doc.in_custom)
					c = CH_GT;
				else if (doc.in_array)
					c = CH_RSQ;
				else if (doc.in_quote)
					c = doc.escape ? 8'h61 : CH_QUOTE;
				else
					c = CH_RCUR;
				counted++;
				send_word(c, 1'b0, 1'b0, '0);
			end
			counted++;
			send_word(8'($urandom), 1'b1, 1'b0, '0);
			if ($urandom_range(0, 7) == 0)
				hold_until_drained();
		end

		text_in.valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : result_sink
		int unsigned stall;
		result_out.ready = 1'b0;
		recv_burst = 1'b0;
		@(negedge clk);
		forever begin
			stall = recv_burst ? 0 : $urandom_range(0, 18);
			if ($urandom_range(0, 59) == 0)
				recv_burst = !recv_burst;
			if (stall > 0) begin
				result_out.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_out.ready <= 1'b1;
			@(posedge clk);
			while (!result_out.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_out.valid && result_out.ready) begin
			if (verdict_q.size() == 0) begin
				$error("result word with no expectation pending");
				mismatches++;
			end else begin
				want = verdict_q.pop_front();
				if (result_out.error_code !== want.code) begin
					$error("error_code: expected %0d, got %0d", want.code, result_out.error_code);
					mismatches++;
				end
				if (result_out.finished !== want.finished) begin
					$error("finished: expected %0d, got %0d", want.finished, result_out.finished);
					mismatches++;
				end
				if (result_out.accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, result_out.accepted);
					mismatches++;
				end
			end
		end
		if ((result_out.valid && result_out.ready) || (text_in.valid && text_in.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
	end

endmodule
